/* src/ip_address_arith_unit_top_defines.svh */
// Assertion macros shared by the address arithmetic unit.
`ifndef IP_ADDRESS_ARITH_UNIT_TOP_DEFINES_SVH
`define IP_ADDRESS_ARITH_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define IAAU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("iaau: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define IAAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("iaau: next-cycle check failed");

`endif

/* src/iaau_pkg.sv */
// Shared types, widths and operation codes of the address arithmetic unit.
package iaau_pkg;

  localparam int HALF_W = 64;
  localparam int ADDR_W = 2 * HALF_W;
  localparam int V4_W   = 32;
  localparam int SUM_W  = ADDR_W + 2;
  localparam int SH_W   = 7;
  localparam int V4SH_W = 5;

  typedef enum logic [3:0] {
    ACT_V4_NEG  = 4'd0,
    ACT_V4_ADDS = 4'd1,
    ACT_V4_SUBS = 4'd2,
    ACT_V4_ADDA = 4'd3,
    ACT_V4_SUBA = 4'd4,
    ACT_V4_SHR  = 4'd5,
    ACT_V4_SHL  = 4'd6,
    ACT_V6_NEG  = 4'd7,
    ACT_V6_NOT  = 4'd8,
    ACT_V6_ADDS = 4'd9,
    ACT_V6_SUBS = 4'd10,
    ACT_V6_ADDA = 4'd11,
    ACT_V6_SUBA = 4'd12,
    ACT_V6_SHR  = 4'd13,
    ACT_V6_SHL  = 4'd14
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [HALF_W-1:0]   addr_hi;
    logic [HALF_W-1:0]   addr_lo;
    logic [HALF_W-1:0]   other_hi;
    logic [HALF_W-1:0]   other_lo;
    logic signed [HALF_W-1:0] scalar;
  } in_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] result_hi;
    logic [HALF_W-1:0] result_lo;
    logic              valid_res;
  } res_item_t;

  // Shifter control handed from decode
  typedef struct packed {
    logic is_v6;
    logic left;
  } shift_ctrl_t;

endpackage

/* src/iaau_if.sv */
// Valid/ready channel interfaces for operation requests and results.
interface iaau_req_if;
  logic                           valid;
  logic                           ready;
  iaau_pkg::action_t              action;
  logic [iaau_pkg::HALF_W-1:0]    addr_hi;
  logic [iaau_pkg::HALF_W-1:0]    addr_lo;
  logic [iaau_pkg::HALF_W-1:0]    other_hi;
  logic [iaau_pkg::HALF_W-1:0]    other_lo;
  logic signed [iaau_pkg::HALF_W-1:0] scalar;

  modport source (output valid, action, addr_hi, addr_lo, other_hi, other_lo, scalar,
                  input ready);
  modport sink (input valid, action, addr_hi, addr_lo, other_hi, other_lo, scalar,
                output ready);
endinterface

interface iaau_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [iaau_pkg::HALF_W-1:0] result_hi;
  logic [iaau_pkg::HALF_W-1:0] result_lo;
  logic                        valid_res;

  modport source (output valid, result_hi, result_lo, valid_res, input ready);
  modport sink (input valid, result_hi, result_lo, valid_res, output ready);
endinterface

/* src/iaau_addsub.sv */
// Shared 130-bit add/subtract with IPv4 and IPv6 range checks.
module iaau_addsub (
  input  logic [iaau_pkg::SUM_W-1:0] x,
  input  logic [iaau_pkg::SUM_W-1:0] y,
  input  logic                       sub,
  output logic [iaau_pkg::SUM_W-1:0] sum,
  output logic                       ok_v4,
  output logic                       ok_v6
);

  // Operands are sign- or zero-extended, so the exact result fits
  assign sum = sub ? (x - y) : (x + y);

  // In range when nothing is set above the address width
  assign ok_v4 = ~|sum[iaau_pkg::SUM_W-1:iaau_pkg::V4_W];
  assign ok_v6 = ~|sum[iaau_pkg::SUM_W-1:iaau_pkg::ADDR_W];

endmodule

/* src/iaau_shift.sv */
// Left/right barrel shifter for IPv4 and IPv6 addresses with count checks.
module iaau_shift (
  input  logic [iaau_pkg::ADDR_W-1:0]        addr,
  input  logic signed [iaau_pkg::HALF_W-1:0] scalar,
  input  iaau_pkg::shift_ctrl_t              ctrl,
  output logic [iaau_pkg::ADDR_W-1:0]        value,
  output logic                               ok
);

  logic [iaau_pkg::V4_W-1:0]   a4;
  logic [iaau_pkg::V4_W-1:0]   v4_val;
  logic                        v4_big;
  logic [iaau_pkg::SH_W-1:0]   n6;
  logic [iaau_pkg::V4SH_W-1:0] n4;
  logic [iaau_pkg::ADDR_W-1:0] v6_val;

  assign a4 = addr[iaau_pkg::V4_W-1:0];
  assign n4 = scalar[iaau_pkg::V4SH_W-1:0];
  assign n6 = scalar[iaau_pkg::SH_W-1:0];

  // IPv4: count of 32 or more flushes to zero
  assign v4_big = |scalar[iaau_pkg::V4_W-2:iaau_pkg::V4SH_W];
  assign v4_val = v4_big ? '0 : (ctrl.left ? (a4 << n4) : (a4 >> n4));

  // IPv6: 128-bit shift, count checked below
  assign v6_val = ctrl.left ? (addr << n6) : (addr >> n6);

  always_comb begin
    if (ctrl.is_v6) begin
      value = v6_val;
      ok    = ~scalar[iaau_pkg::HALF_W-1] & ~|scalar[iaau_pkg::HALF_W-2:iaau_pkg::SH_W];
    end else begin
      value = {{(iaau_pkg::ADDR_W-iaau_pkg::V4_W){1'b0}}, v4_val};
      ok    = ~scalar[iaau_pkg::V4_W-1];
    end
  end

endmodule

/* src/iaau_alu.sv */
// Operation decode and result selection for one request.
module iaau_alu (
  input  iaau_pkg::in_item_t  item,
  output iaau_pkg::res_item_t res
);

  logic [iaau_pkg::ADDR_W-1:0] a128;
  logic [iaau_pkg::ADDR_W-1:0] b128;
  logic [iaau_pkg::SUM_W-1:0]  a4_ext;
  logic [iaau_pkg::SUM_W-1:0]  b4_ext;
  logic [iaau_pkg::SUM_W-1:0]  a6_ext;
  logic [iaau_pkg::SUM_W-1:0]  b6_ext;
  logic [iaau_pkg::SUM_W-1:0]  s4_ext;
  logic [iaau_pkg::SUM_W-1:0]  s6_ext;
  logic [iaau_pkg::SUM_W-1:0]  x;
  logic [iaau_pkg::SUM_W-1:0]  y;
  logic                        sub;
  logic [iaau_pkg::SUM_W-1:0]  sum;
  logic                        ok_v4;
  logic                        ok_v6;
  iaau_pkg::shift_ctrl_t       sh_ctrl;
  logic [iaau_pkg::ADDR_W-1:0] sh_val;
  logic                        sh_ok;
  logic [iaau_pkg::ADDR_W-1:0] val;
  logic                        ok;

  assign a128   = {item.addr_hi, item.addr_lo};
  assign b128   = {item.other_hi, item.other_lo};
  assign a4_ext = {{(iaau_pkg::SUM_W-iaau_pkg::V4_W){1'b0}},
                   item.addr_lo[iaau_pkg::V4_W-1:0]};
  assign b4_ext = {{(iaau_pkg::SUM_W-iaau_pkg::V4_W){1'b0}},
                   item.other_lo[iaau_pkg::V4_W-1:0]};
  assign a6_ext = {2'b00, a128};
  assign b6_ext = {2'b00, b128};
  assign s4_ext = {{(iaau_pkg::SUM_W-iaau_pkg::V4_W){item.scalar[iaau_pkg::V4_W-1]}},
                   item.scalar[iaau_pkg::V4_W-1:0]};
  assign s6_ext = {{(iaau_pkg::SUM_W-iaau_pkg::HALF_W){item.scalar[iaau_pkg::HALF_W-1]}},
                   item.scalar};

  iaau_addsub u_addsub (
    .x     (x),
    .y     (y),
    .sub   (sub),
    .sum   (sum),
    .ok_v4 (ok_v4),
    .ok_v6 (ok_v6)
  );

  iaau_shift u_shift (
    .addr   (a128),
    .scalar (item.scalar),
    .ctrl   (sh_ctrl),
    .value  (sh_val),
    .ok     (sh_ok)
  );

  // Decode: pick adder operands or shifter, and the range check
  always_comb begin
    x            = '0;
    y            = '0;
    sub          = 1'b0;
    sh_ctrl      = '0;
    val          = '0;
    ok           = 1'b0;
    unique case (item.action)
      iaau_pkg::ACT_V4_NEG: begin
        y   = a4_ext;
        sub = 1'b1;
        val = {{(iaau_pkg::ADDR_W-iaau_pkg::V4_W){1'b0}}, sum[iaau_pkg::V4_W-1:0]};
        ok  = 1'b1;
      end
      iaau_pkg::ACT_V4_ADDS, iaau_pkg::ACT_V4_SUBS,
      iaau_pkg::ACT_V4_ADDA, iaau_pkg::ACT_V4_SUBA: begin
        x   = a4_ext;
        y   = (item.action == iaau_pkg::ACT_V4_ADDS ||
               item.action == iaau_pkg::ACT_V4_SUBS) ? s4_ext : b4_ext;
        sub = (item.action == iaau_pkg::ACT_V4_SUBS ||
               item.action == iaau_pkg::ACT_V4_SUBA);
        val = {{(iaau_pkg::ADDR_W-iaau_pkg::V4_W){1'b0}}, sum[iaau_pkg::V4_W-1:0]};
        ok  = ok_v4;
      end
      iaau_pkg::ACT_V4_SHR, iaau_pkg::ACT_V4_SHL,
      iaau_pkg::ACT_V6_SHR, iaau_pkg::ACT_V6_SHL: begin
        sh_ctrl.is_v6 = (item.action == iaau_pkg::ACT_V6_SHR ||
                         item.action == iaau_pkg::ACT_V6_SHL);
        sh_ctrl.left  = (item.action == iaau_pkg::ACT_V4_SHL ||
                         item.action == iaau_pkg::ACT_V6_SHL);
        val = sh_val;
        ok  = sh_ok;
      end
      iaau_pkg::ACT_V6_NEG: begin
        y   = a6_ext;
        sub = 1'b1;
        val = sum[iaau_pkg::ADDR_W-1:0];
        ok  = 1'b1;
      end
      iaau_pkg::ACT_V6_NOT: begin
        val = ~a128;
        ok  = 1'b1;
      end
      iaau_pkg::ACT_V6_ADDS, iaau_pkg::ACT_V6_SUBS,
      iaau_pkg::ACT_V6_ADDA, iaau_pkg::ACT_V6_SUBA: begin
        x   = a6_ext;
        y   = (item.action == iaau_pkg::ACT_V6_ADDS ||
               item.action == iaau_pkg::ACT_V6_SUBS) ? s6_ext : b6_ext;
        sub = (item.action == iaau_pkg::ACT_V6_SUBS ||
               item.action == iaau_pkg::ACT_V6_SUBA);
        val = sum[iaau_pkg::ADDR_W-1:0];
        ok  = ok_v6;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // Clear the value whenever the result is out of range
  assign res.result_hi = ok ? val[iaau_pkg::ADDR_W-1:iaau_pkg::HALF_W] : '0;
  assign res.result_lo = ok ? val[iaau_pkg::HALF_W-1:0] : '0;
  assign res.valid_res = ok;

endmodule

/* src/ip_address_arith_unit_top.sv */
// Top level of the address arithmetic unit: input stage, datapath, result stage.
//
//   channel | dir | payload
//   --------+-----+-------------------------------------------------------------
//   req     | in  | action, addr_hi, addr_lo, other_hi, other_lo, scalar
//   rsp     | out | result_hi, result_lo, valid_res
//
// One request per cycle is taken unless the result side stalls; each result
// passes the input register, then the result register around one add, shift or NOT.
// rst is synchronous and clears only the two stage valid flags.
// A stalled result holds in its register; the input stage keeps taking a new
// transfer as long as the item ahead of it can move into the result register.
module ip_address_arith_unit_top (
  input logic       clk,
  input logic       rst,
  iaau_req_if.sink  req,
  iaau_rsp_if.source rsp
);

  logic                 s1_valid;
  iaau_pkg::in_item_t   s1_item;
  logic                 s1_ready;
  logic                 s2_valid;
  logic                 s2_ready;
  iaau_pkg::res_item_t  alu_res;
  iaau_pkg::res_item_t  s2_res;
  logic                 s2_blank;

  assign s2_ready  = ~s2_valid | rsp.ready;
  assign s1_ready  = ~s1_valid | s2_ready;
  assign req.ready = s1_ready;

  // Input stage: capture on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && s1_ready) begin
      s1_item <= '{action:   req.action,
                   addr_hi:  req.addr_hi,
                   addr_lo:  req.addr_lo,
                   other_hi: req.other_hi,
                   other_lo: req.other_lo,
                   scalar:   req.scalar};
    end
  end

  iaau_alu u_alu (
    .item (s1_item),
    .res  (alu_res)
  );

  // Result stage: advance when empty or drained
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_res <= alu_res;
    end
  end

  assign rsp.valid     = s2_valid;
  assign rsp.result_hi = s2_res.result_hi;
  assign rsp.result_lo = s2_res.result_lo;
  assign rsp.valid_res = s2_res.valid_res;

  // Flag an all-zero value in the result register
  assign s2_blank = (s2_res.result_hi == '0) && (s2_res.result_lo == '0);

`include "ip_address_arith_unit_top_defines.svh"

  // An out-of-range result carries a zero value
  `IAAU_ASSERT_NOW(a_invalid_zero, s2_valid && !s2_res.valid_res, s2_blank)
  // A transfer in always lands in the input stage
  `IAAU_ASSERT_NEXT(a_take_lands, req.valid && s1_ready, s1_valid)
  // An item in the input stage is kept while the result stage is blocked
  `IAAU_ASSERT_NEXT(a_s1_kept, s1_valid && !s2_ready, s1_valid && $stable(s1_item))

endmodule
